/* rtl/irml_pkg.sv */
`timescale 1ns / 1ps
package irml_pkg;

	localparam int unsigned SampleW  = 10;
	localparam int unsigned ChanW    = 3;
	localparam int unsigned DistW    = 14;
	localparam int unsigned CfgW     = 16;
	localparam int unsigned WindowDefault   = 5;
	localparam int unsigned ChannelsDefault = 8;
	localparam logic [CfgW-1:0] CurveMapReset = 16'h3210;

	// polynomial accumulator width, signed, holds every Horner partial
	localparam int unsigned AccW = 64;

	typedef struct packed {
		logic [ChanW-1:0]   channel;
		logic [SampleW-1:0] sample;
	} in_item_t;

	typedef struct packed {
		logic [ChanW-1:0]   channel_out;
		logic [SampleW-1:0] median_reading;
		logic [DistW-1:0]   distance;
	} out_item_t;

	typedef enum logic [1:0] {
		CURVE_SHORT  = 2'd0,
		CURVE_LONG_B = 2'd1,
		CURVE_LONG_C = 2'd2,
		CURVE_LONG_D = 2'd3
	} curve_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;       // capture the accepted item
		logic win_write;  // write the sample into the window
		logic rank_clear; // start the median scan
		logic rank_step;  // test one candidate against all held samples
		logic horner_init;
		logic horner_mul; // p * r into the product register
		logic horner_add; // product plus next coefficient
		logic finish;     // clamp and scale
		logic scale_step; // one step of the reciprocal scaling
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic bad_channel;
		logic rank_last;
		logic horner_last;
		logic scale_last;
	} dp_status_t;

	localparam logic signed [AccW-1:0] Scale = 64'sd10000000000000;
	localparam logic signed [AccW-1:0] Half  = 64'sd5000000000000;

	function automatic logic signed [AccW-1:0] coef(input curve_t c, input logic [2:0] k);
		logic signed [AccW-1:0] r;
		r = '0;
		case (c)
			CURVE_SHORT: case (k)
				3'd0: r = 64'sd9520;
				3'd1: r = -64'sd17370000;
				3'd2: r = 64'sd11690000000;
				3'd3: r = -64'sd3560000000000;
				default: r = 64'sd472270000000000;
			endcase
			CURVE_LONG_B: case (k)
				3'd0: r = 64'sd14890;
				3'd1: r = -64'sd27030000;
				3'd2: r = 64'sd18080000000;
				3'd3: r = -64'sd5670000000000;
				default: r = 64'sd844060000000000;
			endcase
			CURVE_LONG_C: case (k)
				3'd0: r = 64'sd8933;
				3'd1: r = -64'sd18260000;
				3'd2: r = 64'sd13590000000;
				3'd3: r = -64'sd4750000000000;
				default: r = 64'sd787760000000000;
			endcase
			default: case (k)
				3'd0: r = -64'sd4113;
				3'd1: r = -64'sd39180;
				3'd2: r = 64'sd4522000000;
				3'd3: r = -64'sd2860000000000;
				default: r = 64'sd643500000000000;
			endcase
		endcase
		return r;
	endfunction

endpackage

/* rtl/irml_datapath.sv */
`timescale 1ns / 1ps
module irml_datapath #(
	parameter int unsigned WINDOW   = irml_pkg::WindowDefault,
	parameter int unsigned CHANNELS = irml_pkg::ChannelsDefault
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  irml_pkg::in_item_t           in_item,
	input  logic [irml_pkg::CfgW-1:0]    curve_map,
	input  irml_pkg::dp_cmd_t            cmd,
	output irml_pkg::dp_status_t         status,
	output irml_pkg::out_item_t          out_item
);
	import irml_pkg::*;

	localparam int unsigned SlotW  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int unsigned CntW   = $clog2(WINDOW + 1);
	localparam int unsigned ChIdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	// 10^13 = 2^13 * 5^13; floor(2^52 / 5^13) for the reciprocal estimate
	localparam logic [21:0] RecipE13 = 22'd3689348;
	localparam logic [30:0] Pow5E13  = 31'd1220703125;

	// one word per channel holds its whole window, so every slot has its own comparator
	logic [WINDOW-1:0][SampleW-1:0] win_q [CHANNELS];
	logic [CntW-1:0]    fill_q [CHANNELS];
	logic [SlotW-1:0]   wslot_q [CHANNELS];

	logic [ChanW-1:0]   ch_q;
	logic [SampleW-1:0] smp_q;
	logic               bad_q;
	logic [SlotW-1:0]   cand_q;
	logic [SampleW-1:0] med_q;
	logic               found_q;
	logic [2:0]         k_q;
	curve_t             curve_q;
	logic signed [AccW-1:0] p_q;
	logic signed [AccW-1:0] prod_q;
	logic [AccW-1:0]    num_q;
	logic [45:0]        recip_q;
	logic [44:0]        chk_q;
	logic [DistW-1:0]   quo_q;
	logic [2:0]         step_q;

	logic [ChIdxW-1:0]  chi;
	logic [CntW-1:0]    n_cur;
	logic [SampleW-1:0] cand_v;
	logic [CntW-1:0]    n_less, n_le;
	logic [CntW-1:0]    half_n;
	logic [44:0]        rem_v;

	assign chi    = bad_q ? '0 : ChIdxW'(ch_q);
	assign n_cur  = fill_q[chi];
	assign cand_v = win_q[chi][cand_q];
	assign half_n = n_cur >> 1;

	// rank of the candidate among held samples
	always_comb begin
		n_less = '0;
		n_le   = '0;
		for (int i = 0; i < WINDOW; i++) begin
			if (CntW'(i) < n_cur) begin
				if (win_q[chi][i] < cand_v)  n_less = n_less + 1'b1;
				if (win_q[chi][i] <= cand_v) n_le   = n_le + 1'b1;
			end
		end
	end

	// scaled value over 2^13, minus the estimated quotient times 5^13
	assign rem_v = 45'(num_q[56:13]) - chk_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				fill_q[c]  <= '0;
				wslot_q[c] <= '0;
				win_q[c]   <= '0;
			end
		end else if (cmd.win_write && !bad_q) begin
			win_q[chi][wslot_q[chi]] <= smp_q;
			wslot_q[chi] <= (wslot_q[chi] == SlotW'(WINDOW-1)) ? '0
				: wslot_q[chi] + 1'b1;
			if (fill_q[chi] != CntW'(WINDOW))
				fill_q[chi] <= fill_q[chi] + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ch_q  <= in_item.channel;
			smp_q <= in_item.sample;
			bad_q <= (32'(in_item.channel) >= CHANNELS);
		end
		if (cmd.rank_clear) begin
			cand_q  <= '0;
			found_q <= 1'b0;
			med_q   <= '0;
			curve_q <= curve_t'(curve_map[2*ch_q +: 2]);
		end else if (cmd.rank_step) begin
			if (!found_q && n_less <= half_n && half_n < n_le) begin
				med_q   <= cand_v;
				found_q <= 1'b1;
			end
			cand_q <= cand_q + 1'b1;
		end
		if (cmd.horner_init) begin
			if (bad_q) med_q <= '0;
			p_q <= coef(curve_q, 3'd0);
			k_q <= 3'd1;
		end else if (cmd.horner_mul) begin
			prod_q <= p_q * $signed({1'b0, med_q});
		end else if (cmd.horner_add) begin
			p_q <= prod_q + coef(curve_q, k_q);
			k_q <= k_q + 1'b1;
		end
		if (cmd.finish) begin
			if (p_q < 0) num_q <= 64'(Half);
			else if (p_q > ((curve_q == CURVE_SHORT) ? 64'sd10 : 64'sd40) * Scale)
				num_q <= 64'(((curve_q == CURVE_SHORT) ? 64'sd10 : 64'sd40) * Scale * 256 + Half);
			else num_q <= {p_q[AccW-9:0], 8'd0} + 64'(Half);
			quo_q  <= '0;
			step_q <= '0;
		end else if (cmd.scale_step) begin
			// estimate is at most one below the true quotient, one compare fixes it
			case (step_q)
				3'd0: recip_q <= num_q[56:33] * RecipE13;
				3'd1: quo_q <= recip_q[45:32];
				3'd2: chk_q <= quo_q * Pow5E13;
				3'd3: if (rem_v >= 45'(Pow5E13)) quo_q <= quo_q + 1'b1;
				default: ;
			endcase
			step_q <= step_q + 1'b1;
		end
		if (cmd.out_load) begin
			out_item.channel_out    <= ch_q;
			out_item.median_reading <= bad_q ? '0 : med_q;
			out_item.distance       <= bad_q ? '0 : quo_q;
		end
	end

	assign status.bad_channel = bad_q;
	assign status.rank_last   = (cand_q == SlotW'(WINDOW-1));
	assign status.horner_last = (k_q == 3'd4);
	assign status.scale_last  = (step_q == 3'd4);

endmodule

/* rtl/irml_ctrl.sv */
`timescale 1ns / 1ps
module irml_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	input  irml_pkg::dp_status_t  status,
	output irml_pkg::dp_cmd_t     cmd
);
	import irml_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_WRITE = 8'b0000_0010,
		S_RANK  = 8'b0000_0100,
		S_INIT  = 8'b0000_1000,
		S_MUL   = 8'b0001_0000,
		S_ADD   = 8'b0010_0000,
		S_FIN   = 8'b0100_0000,
		S_DIV   = 8'b1000_0000
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		cmd.load        = (state_q == S_IDLE) && in_valid;
		cmd.win_write   = (state_q == S_WRITE);
		cmd.rank_clear  = (state_q == S_WRITE);
		cmd.rank_step   = (state_q == S_RANK);
		cmd.horner_init = (state_q == S_INIT);
		cmd.horner_mul  = (state_q == S_MUL);
		cmd.horner_add  = (state_q == S_ADD);
		cmd.finish      = (state_q == S_FIN);
		cmd.scale_step  = (state_q == S_DIV) && !status.scale_last;
		cmd.out_load    = (state_q == S_DIV) && status.scale_last && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// a new result replaces the one handed over in the same cycle
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE:  if (in_valid) state_q <= S_WRITE;
				S_WRITE: state_q <= S_RANK;
				S_RANK:  if (status.rank_last) state_q <= S_INIT;
				S_INIT:  state_q <= S_MUL;
				S_MUL:   state_q <= S_ADD;
				S_ADD:   state_q <= status.horner_last ? S_FIN : S_MUL;
				S_FIN:   state_q <= S_DIV;
				S_DIV: begin
					// last step loads the result once the output register is free
					if (cmd.out_load) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* rtl/ir_range_median_linearizer_unit.sv */
`timescale 1ns / 1ps
// Per-channel running median of the last WINDOW samples, linearized to a distance in
// 1/256 inch by the channel's quartic curve. One item at a time: the next input is taken
// only after the previous item has passed the median scan (one candidate per cycle), the
// Horner evaluation on a 64 x 11 multiplier and a four-step reciprocal scaling by 10^13.
// A finished result waits in an output register; the next item is taken meanwhile, and
// its own result is held back until that register is free.
module ir_range_median_linearizer_unit #(
	parameter int unsigned WINDOW   = irml_pkg::WindowDefault,
	parameter int unsigned CHANNELS = irml_pkg::ChannelsDefault
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  irml_pkg::in_item_t         in_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output irml_pkg::out_item_t        out_data,
	input  logic                       cfg_we,
	input  logic [irml_pkg::CfgW-1:0]  cfg_wdata
);
	import irml_pkg::*;

	logic [CfgW-1:0] curve_map_q;
	dp_cmd_t         cmd;
	dp_status_t      status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) curve_map_q <= CurveMapReset;
		else if (cfg_we) curve_map_q <= cfg_wdata;
	end

	irml_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready,
		.status, .cmd
	);

	irml_datapath #(.WINDOW(WINDOW), .CHANNELS(CHANNELS)) u_dp (
		.clk, .arst_n, .in_item(in_data), .curve_map(curve_map_q),
		.cmd, .status, .out_item(out_data)
	);

endmodule
